[design/assert_macros.svh]
// Assertion helpers; clk and rst_n must be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define USM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define USM_ASSERT_NEXT(lbl, pre, post, msg) \
  `USM_ASSERT(lbl, (pre) |=> (post), msg)

`endif

[design/usm_pkg.sv]
package usm_pkg;

  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned TEX_BITS   = 16;
  localparam int unsigned DIV_SH     = (ANGLE_BITS > TEX_BITS) ? ANGLE_BITS : TEX_BITS;
  localparam int unsigned DIV_NW     = DIV_SH + 9;
  localparam int unsigned DIV_DW     = 9;
  localparam int unsigned SIN_LAT    = 16;
  localparam int unsigned HRN_N      = 6;
  localparam int unsigned OUT_BITS   = 178;
  localparam int unsigned OUT_W      = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Horner divisors k = 2^e * odd; floor(p/odd) by reciprocal m = ceil(2^s/odd)
  localparam int unsigned HRN_E [HRN_N] = '{2, 1, 3, 1, 2, 1};
  localparam int unsigned HRN_S [HRN_N] = '{37, 37, 35, 36, 34, 33};
  localparam logic [31:0] HRN_M [HRN_N] = '{
    32'(((64'd1 << 37) + 64'd38) / 64'd39),
    32'(((64'd1 << 37) + 64'd54) / 64'd55),
    32'(((64'd1 << 35) + 64'd8) / 64'd9),
    32'(((64'd1 << 36) + 64'd20) / 64'd21),
    32'(((64'd1 << 34) + 64'd4) / 64'd5),
    32'(((64'd1 << 33) + 64'd2) / 64'd3)
  };

  typedef logic signed [31:0] q30_t;

  typedef enum logic [1:0] {
    REG_RADIUS  = 2'd0,
    REG_COLUMNS = 2'd1,
    REG_ROWS    = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_CELL   = 1'b1
  } op_t;

  typedef struct packed {
    logic        vld;
    op_t         op;
    logic [1:0]  n;
    logic        tri_abd;
    logic [15:0] idx_b;
    logic [15:0] idx_c;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } sb_t;

  // round v / 2^sh to nearest, halves away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] half;
    logic [63:0] r;
    mag  = v[63] ? 64'(-v) : 64'(v);
    half = 64'd1 << (sh - 1);
    r    = (mag + half) >> sh;
    return v[63] ? -signed'(r) : signed'(r);
  endfunction

endpackage

[design/usm_div.sv]
module usm_div
  import usm_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_NW-1:0] quot
);

  logic [DIV_DW-1:0] rem_r   [0:DIV_NW-1];
  logic [DIV_NW-1:0] n_r     [0:DIV_NW-1];
  logic [DIV_DW-1:0] rem_nxt [0:DIV_NW-1];
  logic [DIV_NW-1:0] n_nxt   [0:DIV_NW-1];

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [DIV_DW-1:0] rin;
    logic [DIV_NW-1:0] nin;
    logic [DIV_DW:0]   trial;
    for (int k = 0; k < DIV_NW; k++) begin
      rin   = (k == 0) ? '0 : rem_r[(k == 0) ? 0 : k - 1];
      nin   = (k == 0) ? num : n_r[(k == 0) ? 0 : k - 1];
      trial = {rin, nin[DIV_NW-1]};
      if (trial >= {1'b0, den}) begin
        rem_nxt[k] = DIV_DW'(trial - {1'b0, den});
        n_nxt[k]   = {nin[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[DIV_DW-1:0];
        n_nxt[k]   = {nin[DIV_NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_NW; k++) begin
        rem_r[k] <= rem_nxt[k];
        n_r[k]   <= n_nxt[k];
      end
    end
  end

  assign quot = n_r[DIV_NW-1];

endmodule

[design/usm_sin.sv]
module usm_sin
  import usm_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] phase,
  output q30_t                  sin_q30
);

  localparam int unsigned QB  = ANGLE_BITS - 2;
  localparam int unsigned FW  = QB + 1;
  localparam int unsigned FIN = 2 + 2 * HRN_N;

  logic [FW-1:0] f_ex;
  logic [63:0]   x0_full;
  logic [63:0]   x2_full;
  logic [63:0]   s_full;

  logic [30:0] x_r   [0:FIN-1];
  logic [31:0] x2_r  [1:FIN-3];
  logic        neg_r [0:FIN];
  logic [30:0] p_r   [0:HRN_N-1];
  logic [30:0] q_r   [0:HRN_N-1];
  logic [30:0] s_r;
  q30_t        o_r;

  // fold to the first quarter wave
  assign f_ex = phase[QB] ? (FW'(1) << QB) - FW'(phase[QB-1:0]) : FW'(phase[QB-1:0]);
  assign x0_full = (64'(f_ex) * 64'(HALF_PI_Q30)) >> QB;
  assign x2_full = (64'(x_r[0]) * 64'(x_r[0])) >> 30;
  assign s_full  = (64'(x_r[FIN-1]) * 64'(ONE_Q30 - q_r[HRN_N-1])) >> 30;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= x0_full[30:0];
      neg_r[0] <= phase[ANGLE_BITS-1];
      for (int k = 1; k < FIN; k++) begin
        x_r[k] <= x_r[k-1];
      end
      for (int k = 1; k <= FIN; k++) begin
        neg_r[k] <= neg_r[k-1];
      end
      x2_r[1] <= x2_full[31:0];
      for (int k = 2; k <= FIN - 3; k++) begin
        x2_r[k] <= x2_r[k-1];
      end
      s_r <= (s_full > 64'(ONE_Q30)) ? ONE_Q30 : s_full[30:0];
      o_r <= neg_r[FIN] ? -q30_t'({1'b0, s_r}) : q30_t'({1'b0, s_r});
    end
  end

  // Taylor terms, two stages each: product, then divide by reciprocal
  for (genvar i = 0; i < HRN_N; i++) begin : g_hrn
    logic [30:0] t;
    logic [63:0] pf;
    logic [63:0] qf;
    if (i == 0) begin : g_first
      assign t = ONE_Q30;
    end else begin : g_next
      assign t = ONE_Q30 - q_r[i-1];
    end
    assign pf = (64'(x2_r[1+2*i]) * 64'(t)) >> (30 + HRN_E[i]);
    assign qf = (64'(p_r[i]) * 64'(HRN_M[i])) >> HRN_S[i];
    always_ff @(posedge clk) begin
      if (en) begin
        p_r[i] <= pf[30:0];
        q_r[i] <= qf[30:0];
      end
    end
  end

  assign sin_q30 = o_r;

endmodule

[design/uv_sphere_mesh_generator.sv]
// UV sphere mesh generator.
// Input stream: one request per transfer. in_tuser selects vertex or cell,
// in_tdata carries col and row. Output stream: one vertex result, or zero to
// two triangle results per cell; out_tlast marks the final result of a request.
// Requests outside the grid produce nothing.
// Config: cfg_we/cfg_addr/cfg_wdata write radius, columns, rows; write only
// while no request is in flight.
// Pipeline: 25-stage divider, loaded at the accepting edge, 16-stage sine
// unit, 4 product/rounding stages, 1 output register.
// Throughput: one request per cycle unless the output stalls; a cell with two
// triangles holds the last stage for both on the single output register.
// Reset clears all valid bits and loads radius 1.0, 32 columns, 16 rows.
// When out_tready is low the whole pipeline holds once a result waits in its
// last stage; in_tready drops and nothing is lost or repeated.
`include "assert_macros.svh"

module uv_sphere_mesh_generator
  import usm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,   // col[7:0], row[15:8]
  input  logic             in_tuser,   // operation
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                       // tex_u, tex_v, idx_a, idx_b, idx_c, zero pad
  output logic             out_tlast,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [14:0]      cfg_wdata
);

  localparam int unsigned TEX_ST = DIV_NW;
  localparam int unsigned ST     = DIV_NW + SIN_LAT - 1;
  localparam int unsigned LAST   = ST + 4;
  localparam int unsigned QTR    = 1 << (ANGLE_BITS - 2);

  logic [14:0] radius_r;
  logic [7:0]  columns_r;
  logic [7:0]  rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= 15'd256;
      columns_r <= 8'd32;
      rows_r    <= 8'd16;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_RADIUS:  radius_r  <= cfg_wdata;
        REG_COLUMNS: columns_r <= cfg_wdata[7:0];
        REG_ROWS:    rows_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // request decode
  logic [7:0]  in_col;
  logic [7:0]  in_row;
  op_t         in_op;
  logic [8:0]  stride;
  logic [16:0] row_base;
  logic        top_ok;
  logic        bot_ok;
  sb_t         sb_in;

  assign in_col   = in_tdata[7:0];
  assign in_row   = in_tdata[15:8];
  assign in_op    = op_t'(in_tuser);
  assign stride   = {1'b0, columns_r} + 9'd1;
  assign row_base = 17'(in_row) * 17'(stride);
  assign top_ok   = in_row != 8'd0;
  assign bot_ok   = in_row != (rows_r - 8'd1);

  always_comb begin
    sb_in         = '0;
    sb_in.vld     = in_tvalid;
    sb_in.op      = in_op;
    sb_in.tri_abd = top_ok;
    sb_in.idx_b   = 16'(row_base + 17'(in_col));
    sb_in.idx_c   = 16'(row_base + 17'(in_col) + 17'(stride));
    if (columns_r == 8'd0 || rows_r == 8'd0) begin
      sb_in.n = 2'd0;
    end else if (in_op == OP_VERTEX) begin
      sb_in.n = (in_col <= columns_r && in_row <= rows_r) ? 2'd1 : 2'd0;
    end else if (in_col < columns_r && in_row < rows_r) begin
      sb_in.n = 2'(top_ok) + 2'(bot_ok);
    end else begin
      sb_in.n = 2'd0;
    end
  end

  // output control
  sb_t  lst;
  logic lvld;
  logic out_free;
  logic emit;
  logic done;
  logic en;
  logic phase_r;
  logic out_tvalid_r;
  logic out_tlast_r;
  logic [OUT_W-1:0] out_tdata_r;

  sb_t sb_r [0:LAST];

  assign lst      = sb_r[LAST];
  assign lvld     = lst.vld;
  assign out_free = !out_tvalid_r || out_tready;
  assign emit     = lvld && (lst.n != 2'd0) && out_free;
  assign done     = lvld && ((lst.n == 2'd0) ||
                             (out_free && (lst.n == 2'd1 || phase_r)));
  assign en       = !lvld || done;
  assign in_tready = en;

  // dividers: round(num/den) = floor((2num+den)/(2den))
  logic [DIV_NW-1:0] qa, qu, qp, qv;
  logic [DIV_DW-1:0] den_c, den_r;

  assign den_c = {columns_r, 1'b0};
  assign den_r = {rows_r, 1'b0};

  usm_div u_div_a (
    .clk(clk), .en(en),
    .num((DIV_NW'(in_col) << (ANGLE_BITS + 1)) + DIV_NW'(columns_r)),
    .den(den_c), .quot(qa));
  usm_div u_div_u (
    .clk(clk), .en(en),
    .num((DIV_NW'(in_col) << (TEX_BITS + 1)) + DIV_NW'(columns_r)),
    .den(den_c), .quot(qu));
  usm_div u_div_p (
    .clk(clk), .en(en),
    .num((DIV_NW'(in_row) << ANGLE_BITS) + DIV_NW'(rows_r)),
    .den(den_r), .quot(qp));
  usm_div u_div_v (
    .clk(clk), .en(en),
    .num((DIV_NW'(in_row) << (TEX_BITS + 1)) + DIV_NW'(rows_r)),
    .den(den_r), .quot(qv));

  logic [ANGLE_BITS-1:0] pa;
  logic [ANGLE_BITS-1:0] pp;
  q30_t sa, ca, sp, cp;

  assign pa = qa[ANGLE_BITS-1:0];
  assign pp = qp[ANGLE_BITS-1:0];

  usm_sin u_sin_a (.clk(clk), .en(en), .phase(pa), .sin_q30(sa));
  usm_sin u_cos_a (.clk(clk), .en(en), .phase(pa + ANGLE_BITS'(QTR)), .sin_q30(ca));
  usm_sin u_sin_p (.clk(clk), .en(en), .phase(pp), .sin_q30(sp));
  usm_sin u_cos_p (.clk(clk), .en(en), .phase(pp + ANGLE_BITS'(QTR)), .sin_q30(cp));

  // sideband pipeline, texture coordinates joined at the divider output
  sb_t sb_tex;

  always_comb begin
    sb_tex       = sb_r[TEX_ST-1];
    sb_tex.tex_u = qu[16:0];
    sb_tex.tex_v = 17'h10000 - qv[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST; k++) begin
        sb_r[k].vld <= 1'b0;
      end
    end else if (en) begin
      sb_r[0] <= sb_in;
      for (int k = 1; k <= LAST; k++) begin
        sb_r[k] <= (k == TEX_ST) ? sb_tex : sb_r[k-1];
      end
    end
  end

  // direction, radius scale, rounding
  logic signed [63:0] casp_r, sasp_r;
  q30_t               cp1_r;
  q30_t               dx_r, dy_r, dz_r;
  logic signed [47:0] rx_r, ry_r, rz_r;
  logic [15:0]        nx_r, ny_r, nz_r;
  logic [15:0]        nx4_r, ny4_r, nz4_r;
  logic [15:0]        px_r, py_r, pz_r;

  logic signed [63:0] dx_nxt, dz_nxt;
  logic signed [63:0] nx_nxt, ny_nxt, nz_nxt;
  logic signed [63:0] px_nxt, py_nxt, pz_nxt;
  logic signed [15:0] rad_s;

  assign rad_s  = signed'({1'b0, radius_r});
  assign dx_nxt = -rnd_shift(casp_r, 30);
  assign dz_nxt = rnd_shift(sasp_r, 30);
  assign nx_nxt = rnd_shift(64'(dx_r), 16);
  assign ny_nxt = rnd_shift(64'(dy_r), 16);
  assign nz_nxt = rnd_shift(64'(dz_r), 16);
  assign px_nxt = rnd_shift(64'(rx_r), 30);
  assign py_nxt = rnd_shift(64'(ry_r), 30);
  assign pz_nxt = rnd_shift(64'(rz_r), 30);

  always_ff @(posedge clk) begin
    if (en) begin
      casp_r <= 64'(ca) * 64'(sp);
      sasp_r <= 64'(sa) * 64'(sp);
      cp1_r  <= cp;
      dx_r   <= dx_nxt[31:0];
      dy_r   <= cp1_r;
      dz_r   <= dz_nxt[31:0];
      rx_r   <= 48'(rad_s) * 48'(dx_r);
      ry_r   <= 48'(rad_s) * 48'(dy_r);
      rz_r   <= 48'(rad_s) * 48'(dz_r);
      nx_r   <= nx_nxt[15:0];
      ny_r   <= ny_nxt[15:0];
      nz_r   <= nz_nxt[15:0];
      px_r   <= px_nxt[15:0];
      py_r   <= py_nxt[15:0];
      pz_r   <= pz_nxt[15:0];
      nx4_r  <= nx_r;
      ny4_r  <= ny_r;
      nz4_r  <= nz_r;
    end
  end

  // result select
  logic [15:0]      idx_a, idx_d;
  logic [OUT_W-1:0] out_tdata_nxt;
  logic             out_tlast_nxt;

  assign idx_a = lst.idx_b + 16'd1;
  assign idx_d = lst.idx_c + 16'd1;

  always_comb begin
    out_tdata_nxt = '0;
    out_tlast_nxt = 1'b1;
    if (lst.op == OP_VERTEX) begin
      out_tdata_nxt = OUT_W'({lst.tex_v, lst.tex_u, nz4_r, ny4_r, nx4_r,
                              pz_r, py_r, px_r});
    end else begin
      out_tlast_nxt = (lst.n == 2'd1) || phase_r;
      if (lst.tri_abd && !phase_r) begin
        out_tdata_nxt = OUT_W'({idx_d, lst.idx_b, idx_a, 130'd0});
      end else begin
        out_tdata_nxt = OUT_W'({idx_d, lst.idx_c, lst.idx_b, 130'd0});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      phase_r      <= 1'b0;
    end else begin
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (done) begin
        phase_r <= 1'b0;
      end else if (emit) begin
        phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata_r <= out_tdata_nxt;
      out_tlast_r <= out_tlast_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `USM_ASSERT(a_phase_cell, phase_r |-> (lvld && lst.op == OP_CELL && lst.n == 2'd2), "bad phase")
  `USM_ASSERT(a_stall_src, !in_tready |-> lst.vld, "input stalled with empty last stage")
  `USM_ASSERT_NEXT(a_vtx_last, emit && lst.op == OP_VERTEX, out_tvalid && out_tlast, "no tlast")

endmodule

[tb/sv/uv_sphere_mesh_generator_tb.sv]
`timescale 1ns / 1ps

module uv_sphere_mesh_generator_tb
  import usm_pkg::*;
();

  localparam int NF = 11;
  localparam int WD_LIMIT = 5000;
  localparam int DRAIN = 80;
  localparam int FW [NF] = '{16, 16, 16, 16, 16, 16, 17, 17, 16, 16, 16};
  localparam longint unsigned ONE = 64'd1 << 30;

  typedef struct {
    logic [16:0] f [NF];
    logic        last;
  } mesh_res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [15:0]      in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_addr = '0;
  logic [14:0]      cfg_wdata = '0;

  uv_sphere_mesh_generator dut (.*);

  always #4 clk = ~clk;

  mesh_res_t mesh_q[$];
  longint unsigned sph_radius = 256, sph_cols = 32, sph_rows = 16;
  int  mismatches = 0;
  int  idle_cnt = 0;
  bit  calm = 1'b0;

  function automatic longint quarter_sin(longint unsigned f);
    longint unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
    longint unsigned x, x2, t;
    x = (f * longint'(HALF_PI_Q30)) >> (ANGLE_BITS - 2);
    x2 = (x * x) >> 30;
    t = ONE;
    for (int i = 0; i < 6; i++) t = ONE - ((x2 * t) >> 30) / divs[i];
    t = (x * t) >> 30;
    if (t > ONE) t = ONE;
    return longint'(t);
  endfunction

  function automatic longint phase_sin(logic [15:0] p);
    longint s;
    if (p[14]) s = quarter_sin(64'd16384 - p[13:0]);
    else s = quarter_sin(p[13:0]);
    return p[15] ? -s : s;
  endfunction

  function automatic longint rnd_sh(longint v, int s);
    longint unsigned half;
    half = 64'd1 << (s - 1);
    if (v >= 0) return longint'((longint'(v) + half) >> s);
    return -longint'((longint'(-v) + half) >> s);
  endfunction

  function automatic longint unsigned div_rnd(longint unsigned n, longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic void push_tri(longint unsigned a, longint unsigned b,
                                   longint unsigned c);
    mesh_res_t r;
    foreach (r.f[j]) r.f[j] = '0;
    r.f[8] = a[15:0];
    r.f[9] = b[15:0];
    r.f[10] = c[15:0];
    r.last = 1'b0;
    mesh_q.insert(mesh_q.size(), r);
  endfunction

  function automatic void predict_mesh(op_t op, longint unsigned col, longint unsigned row);
    mesh_res_t r;
    logic [15:0] pa, pp;
    longint sa, ca, sp, cp, dx, dy, dz, rad;
    longint unsigned b, c;
    int n;
    if (sph_cols == 0 || sph_rows == 0) return;
    if (op == OP_VERTEX) begin
      if (col > sph_cols || row > sph_rows) return;
      pa = 16'(div_rnd(col << 16, sph_cols));
      pp = 16'(div_rnd(row << 15, sph_rows));
      sa = phase_sin(pa);
      ca = phase_sin(pa + 16'd16384);
      sp = phase_sin(pp);
      cp = phase_sin(pp + 16'd16384);
      dx = -rnd_sh(ca * sp, 30);
      dy = cp;
      dz = rnd_sh(sa * sp, 30);
      rad = longint'(sph_radius);
      r.f[0] = 17'(rnd_sh(rad * dx, 30) & 64'hFFFF);
      r.f[1] = 17'(rnd_sh(rad * dy, 30) & 64'hFFFF);
      r.f[2] = 17'(rnd_sh(rad * dz, 30) & 64'hFFFF);
      r.f[3] = 17'(rnd_sh(dx, 16) & 64'hFFFF);
      r.f[4] = 17'(rnd_sh(dy, 16) & 64'hFFFF);
      r.f[5] = 17'(rnd_sh(dz, 16) & 64'hFFFF);
      r.f[6] = 17'(div_rnd(col << 16, sph_cols));
      r.f[7] = 17'(65536 - div_rnd(row << 16, sph_rows));
      r.f[8] = '0;
      r.f[9] = '0;
      r.f[10] = '0;
      r.last = 1'b1;
      mesh_q.insert(mesh_q.size(), r);
    end else begin
      if (col >= sph_cols || row >= sph_rows) return;
      b = row * (sph_cols + 1) + col;
      c = (row + 1) * (sph_cols + 1) + col;
      n = 0;
      if (row != 0) begin
        push_tri(b + 1, b, c + 1);
        n++;
      end
      if (row != sph_rows - 1) begin
        push_tri(b, c, c + 1);
        n++;
      end
      if (n > 0) mesh_q[$].last = 1'b1;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    mesh_res_t e;
    logic [16:0] got;
    int off;
    if (rst_n && out_tvalid && out_tready) begin
      if (mesh_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: tdata=%h", out_tdata);
      end else begin
        e = mesh_q.pop_front();
        off = 0;
        for (int j = 0; j < NF; j++) begin
          got = 17'((out_tdata >> off) & ((1 << FW[j]) - 1));
          if (got !== e.f[j]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %h, got %h", j, e.f[j], got);
          end
          off += FW[j];
        end
        if (out_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10) $display("tlast: expected %b, got %b", e.last, out_tlast);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    int stall;
    if (!rst_n) out_tready <= 1'b1;
    else if (stall > 0) begin
      stall--;
      if (stall == 0) out_tready <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall = $urandom_range(1, 17);
      out_tready <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_req(op_t op, int col, int row);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {row[7:0], col[7:0]};
    do @(posedge clk); while (!in_tready);
    predict_mesh(op, col, row);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (mesh_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_sphere(int rad, int cols, int rws);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= REG_RADIUS;
    cfg_wdata <= rad[14:0];
    @(posedge clk);
    cfg_addr <= REG_COLUMNS;
    cfg_wdata <= 15'(cols[7:0]);
    @(posedge clk);
    cfg_addr <= REG_ROWS;
    cfg_wdata <= 15'(rws[7:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
    sph_radius = rad[14:0];
    sph_cols = cols[7:0];
    sph_rows = rws[7:0];
  endtask

  task automatic test_reset_grid();
    send_req(OP_VERTEX, 0, 0);
    send_req(OP_VERTEX, 32, 16);
    send_req(OP_VERTEX, 16, 8);
    send_req(OP_VERTEX, 7, 3);
    send_req(OP_VERTEX, 33, 0);
    send_req(OP_VERTEX, 0, 17);
    send_req(OP_VERTEX, 255, 255);
    send_req(OP_CELL, 0, 0);
    send_req(OP_CELL, 31, 15);
    send_req(OP_CELL, 5, 5);
    send_req(OP_CELL, 32, 0);
    send_req(OP_CELL, 0, 16);
    send_req(OP_CELL, 255, 255);
  endtask

  task automatic test_corner_configs();
    set_sphere(0, 1, 1);
    send_req(OP_VERTEX, 1, 1);
    send_req(OP_VERTEX, 0, 0);
    send_req(OP_CELL, 0, 0);
    set_sphere(32767, 255, 255);
    send_req(OP_VERTEX, 255, 255);
    send_req(OP_VERTEX, 128, 128);
    send_req(OP_VERTEX, 85, 170);
    send_req(OP_CELL, 254, 254);
    send_req(OP_CELL, 254, 0);
    send_req(OP_CELL, 0, 127);
    send_req(OP_CELL, 255, 3);
  endtask

  task automatic test_random(int n);
    int col, row;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        col = $urandom_range(0, 255);
        row = $urandom_range(0, 255);
      end else begin
        col = $urandom_range(0, int'(sph_cols));
        row = $urandom_range(0, int'(sph_rows));
      end
      send_req($urandom_range(0, 1) ? OP_CELL : OP_VERTEX, col, row);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_grid();
    test_corner_configs();
    set_sphere(256, 32, 16);
    test_random(160);
    set_sphere(32767, 255, 255);
    test_random(160);
    set_sphere(0, 1, 1);
    test_random(60);
    set_sphere($urandom_range(0, 32767), $urandom_range(1, 255), $urandom_range(1, 255));
    test_random(160);
    set_sphere($urandom_range(0, 32767), $urandom_range(1, 8), $urandom_range(1, 8));
    test_random(160);
    set_sphere($urandom_range(0, 32767), $urandom_range(1, 255), $urandom_range(1, 255));
    calm = 1'b1;
    test_random(200);
    wait_idle();
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
